### design/indexed_ordered_list_top_macros.svh
// ---------------------------------------------------------------------------
// indexed_ordered_list_top_macros
// Assertion macros used by the checker of the indexed ordered list.
// ---------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_TOP_MACROS_SVH
`define INDEXED_ORDERED_LIST_TOP_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define IOL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define IOL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/iol_pkg.sv
// ---------------------------------------------------------------------------
// iol_pkg
// Operation codes, status codes and cell control type of the ordered list.
// ---------------------------------------------------------------------------
package iol_pkg;

   // request operations
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_READ   = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   // field widths fixed by the interface
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;

   // per-cell update control
   typedef struct packed {
      logic load;        // take the new value
      logic take_left;   // shift back: take the entry in front
      logic take_right;  // close gap: take the entry behind
   } iol_cell_ctl_type;

endpackage

### design/indexed_ordered_list_top.sv
// ---------------------------------------------------------------------------
// indexed_ordered_list_top
// Bounded ordered list with insert, delete and read at a list position.
// ---------------------------------------------------------------------------
// The list sits in a row of CAPACITY cells that all shift at once, so no
// request ever has to wait: a word is taken whenever start is high
// (busy is always low), and its result appears on the rsp_ ports with
// rsp_strobe for exactly one cycle, the cycle after the request was taken.
// Requests may come in every cycle, one result per cycle. The result cannot
// be held off, so the receiver must take it in that cycle. Errors leave the
// list unchanged and return zero data. Stored entries have no reset; only
// the fill count and the result strobe are cleared.
module indexed_ordered_list_top
   import iol_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [1:0]                req_mode,
   input  logic [POS_W-1:0]          req_position,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_strobe,
   output logic signed [VALUE_W-1:0] rsp_data,
   output logic [1:0]                rsp_status,
   output logic [COUNT_W-1:0]        rsp_count
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int AW = $clog2(CAPACITY);

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  strobe_ff;
   logic [VALUE_W-1:0]    data_ff;
   logic [VALUE_W-1:0]    data_in;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   logic [COUNT_W-1:0]    rcount_ff;

   logic                  accept;
   logic                  do_insert;
   logic                  do_delete;
   logic                  hit;
   logic [PW-1:0]         pos_ext;
   logic [PW-1:0]         cnt_ext;
   logic [63:0]           val_ext;
   logic [63:0]           rd_ext;
   logic [DATA_WIDTH-1:0] rd_entry;
   logic [DATA_WIDTH-1:0] entry_q [CAPACITY];
   iol_cell_ctl_type      cell_ctl [CAPACITY];

   assign busy    = 1'b0;
   assign accept  = start && !busy;
   assign pos_ext = PW'(req_position);
   assign cnt_ext = PW'(count_ff);
   assign val_ext = 64'(req_value);

   // decode request against the fill count
   always_comb begin
      do_insert = 1'b0;
      do_delete = 1'b0;
      hit       = 1'b0;
      status_in = ST_OK;
      case (req_mode)
         MODE_INSERT: begin
            if (cnt_ext == PW'(CAPACITY)) begin
               status_in = ST_FULL;
            end else if (pos_ext > cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               do_insert = 1'b1;
            end
         end
         MODE_DELETE, MODE_READ: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else if (pos_ext >= cnt_ext) begin
               status_in = ST_RANGE;
            end else begin
               hit       = 1'b1;
               do_delete = (req_mode == MODE_DELETE);
            end
         end
         default: begin
            status_in = ST_RANGE;
         end
      endcase
   end

   // entry at the requested position, sign-extended to the data field
   assign rd_entry = entry_q[pos_ext[AW-1:0]];
   assign rd_ext   = 64'(signed'(rd_entry));
   assign data_in  = hit ? rd_ext[VALUE_W-1:0] : '0;

   // fill count update
   always_comb begin
      count_in = count_ff;
      if (accept && do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (accept && do_delete) begin
         count_in = count_ff - 1'b1;
      end
   end

   // row of cells: cells behind the position shift back on insert,
   // cells from the position on take their right neighbor on delete
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      always_comb begin
         cell_ctl[k].load       = accept && do_insert && (PW'(k) == pos_ext);
         cell_ctl[k].take_left  = accept && do_insert && (PW'(k) > pos_ext);
         cell_ctl[k].take_right = accept && do_delete && (PW'(k) >= pos_ext);
      end

      if (k == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_left
         assign left_w = entry_q[k-1];
      end

      if (k == CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_right
         assign right_w = entry_q[k+1];
      end

      iol_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[k]),
         .left_data  (left_w),
         .right_data (right_w),
         .load_data  (val_ext[DATA_WIDTH-1:0]),
         .entry      (entry_q[k])
      );
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   // result word registers
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff   <= data_in;
         status_ff <= status_in;
         rcount_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = signed'(data_ff);
   assign rsp_status = status_ff;
   assign rsp_count  = rcount_ff;

endmodule

### design/iol_cell.sv
// ---------------------------------------------------------------------------
// iol_cell
// One storage cell of the list: holds one entry and can load a new value or
// take the entry of either neighbor.
// ---------------------------------------------------------------------------
module iol_cell
   import iol_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  iol_cell_ctl_type      ctl,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic [DATA_WIDTH-1:0] load_data,
   output logic [DATA_WIDTH-1:0] entry
);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;

   // next entry: new value, left neighbor, right neighbor or hold
   always_comb begin
      if (ctl.load) begin
         entry_in = load_data;
      end else if (ctl.take_left) begin
         entry_in = left_data;
      end else if (ctl.take_right) begin
         entry_in = right_data;
      end else begin
         entry_in = entry_ff;
      end
   end

   // payload register, no reset
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### design/iol_checker.sv
// ---------------------------------------------------------------------------
// iol_checker
// Port-level checks of the ordered list, bound to the top level.
// ---------------------------------------------------------------------------
`include "indexed_ordered_list_top_macros.svh"

module iol_checker
   import iol_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input logic signed [VALUE_W-1:0] rsp_data,
   input logic [1:0]                rsp_status,
   input logic [COUNT_W-1:0]        rsp_count
);

   logic               prev_strobe_ff;
   logic [COUNT_W-1:0] prev_count_ff;
   logic               err_result;
   logic               empty_result;
   logic               back_to_back;
   logic               count_near;

   // result word of the previous cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_strobe_ff <= 1'b0;
      end else begin
         prev_strobe_ff <= rsp_strobe;
      end
      prev_count_ff <= rsp_count;
   end

   // result classes
   assign err_result   = rsp_strobe && (rsp_status != ST_OK);
   assign empty_result = rsp_strobe && (rsp_status == ST_EMPTY);
   assign back_to_back = rsp_strobe && prev_strobe_ff;
   assign count_near   = (rsp_count == prev_count_ff)
                      || (rsp_count == COUNT_W'(prev_count_ff + 1'b1))
                      || (rsp_count == COUNT_W'(prev_count_ff - 1'b1));

   // every taken word gives a result in the next cycle
   `IOL_ASSERT_NEXT(a_result_follows, start && !busy, rsp_strobe, "result missing")

   // failed requests return zero data
   `IOL_ASSERT_NOW(a_err_zero, err_result, rsp_data == '0, "error data not zero")

   // an empty list reports no entries
   `IOL_ASSERT_NOW(a_empty_count, empty_result, rsp_count == '0, "empty with entries")

   // back-to-back results move the count by at most one
   `IOL_ASSERT_NOW(a_count_step, back_to_back, count_near, "count jumped")

endmodule

bind indexed_ordered_list_top iol_checker u_iol_checker (.*);
